>>> hw/rtl/profile_grid_interpolator_defines.svh
// Assertion macros for the profile grid interpolator.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef PROFILE_GRID_INTERPOLATOR_DEFINES_SVH
`define PROFILE_GRID_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define PGI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pgi_pkg.sv
// Shared types and constants of the profile grid interpolator.
// No dependencies; imported by pgi_div and profile_grid_interpolator.
`timescale 1ns / 1ps

package pgi_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_GRID   = 4096;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PTR_W + 1;
    localparam int GRID_W     = 12;
    localparam int DEPTH_W    = 24;
    localparam int INV_W      = 24;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = DEPTH_W + INV_W;
    localparam int RND_SHIFT  = 28;
    localparam int LD_CNT_W   = $clog2(DEPTH_W);
    localparam int DIV_W      = VAL_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [GRID_W-1:0] EFF_MAX       = GRID_W'(MAX_GRID - 2);
    localparam logic [GRID_W-1:0] GRID_STEPS_RST = GRID_W'(1022);
    localparam logic [INV_W-1:0]  INV_SPACING_RST = INV_W'(1048576);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_EM_CHK,
        ST_SC_RD,
        ST_SC_CMP,
        ST_DIV,
        ST_MUL,
        ST_EM_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hw/rtl/pgi_div.sv
// Bit-serial restoring divider: unsigned dividend by unsigned grid span.
// Depends on pgi_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module pgi_div
    import pgi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [GRID_W-1:0] divisor,
    output logic [DIV_W-1:0]  quotient,
    output div_stat_t         stat
);

    logic [GRID_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [GRID_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [GRID_W:0]      trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? GRID_W'(trial - {1'b0, dvs_reg}) : trial[GRID_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/profile_grid_interpolator.sv
// Top level of the profile grid interpolator: breakpoint table, cursor, serial datapath.
// Depends on pgi_pkg, pgi_div and profile_grid_interpolator_defines.svh.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  func, depth, point_value, first_point
//   out      source     out_valid/out_stall  grid_index, sample_value, last_sample, table_empty
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. A load runs the bit-serial index multiplier, then writes the table.
// An emit inside the current segment goes from the check straight to output; entering a new
// segment costs a table scan, a read and compare per breakpoint, then the divider and multiplier.
// Reset clears count, cursor and the control registers; the table needs no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`include "profile_grid_interpolator_defines.svh"

module profile_grid_interpolator
    import pgi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [DEPTH_W-1:0]       depth,
    input  logic signed [VAL_W-1:0]  point_value,
    input  logic                     first_point,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [GRID_W-1:0]        grid_index,
    output logic signed [VAL_W-1:0]  sample_value,
    output logic                     last_sample,
    output logic                     table_empty,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [GRID_W-1:0]   gs_reg;
    logic [INV_W-1:0]    inv_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [GRID_W-1:0]   cursor_reg;
    logic [GRID_W-1:0]   last_idx_reg;
    logic                cache_valid_reg;
    logic [GRID_W:0]     cache_hi_reg;
    logic [VAL_W-1:0]    cache_step_reg;
    logic [VAL_W-1:0]    cache_acc_reg;
    logic [PTR_W-1:0]    scan_ptr_reg;
    logic [GRID_W-1:0]   prev_idx_reg;
    logic [VAL_W-1:0]    prev_val_reg;
    logic                neg_reg;
    logic [LD_CNT_W-1:0] ld_cnt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [VAL_W-1:0]    ld_val_reg;
    logic [GRID_W-1:0]   mul_k_reg;
    logic [VAL_W-1:0]    mul_m_reg;
    logic [VAL_W-1:0]    res_val_reg;
    logic                res_empty_reg;
    logic                out_valid_reg;
    logic [GRID_W-1:0]   out_idx_reg;
    logic [VAL_W-1:0]    out_val_reg;
    logic                out_last_reg;
    logic                out_empty_reg;

    logic [GRID_W-1:0]   mem_idx [MAX_POINTS];
    logic [VAL_W-1:0]    mem_val [MAX_POINTS];
    logic [GRID_W-1:0]   rd_idx_reg;
    logic [VAL_W-1:0]    rd_val_reg;

    logic                in_accept;
    logic                out_load;
    logic                div_start;
    logic                load_drop;
    logic                hit;
    logic                found;
    logic                at_end;
    logic [GRID_W-1:0]   eff;
    logic [GRID_W:0]     eff_plus1;
    logic [INV_W:0]      mul_sum;
    logic [PROD_W-RND_SHIFT:0] rnd;
    logic [GRID_W-1:0]   idx_clamp;
    logic [GRID_W-1:0]   idx_final;
    logic [DIV_W-1:0]    diff;
    logic [DIV_W-1:0]    diff_mag;
    logic [DIV_W-1:0]    quotient;
    logic [VAL_W-1:0]    step_val;
    logic                emit_last;
    div_stat_t           div_stat;

    assign eff       = (gs_reg > EFF_MAX) ? EFF_MAX : gs_reg;
    assign eff_plus1 = {1'b0, eff} + 1'b1;
    assign load_drop = (first_point ? CNT_W'(0) : count_reg) >= CNT_W'(MAX_POINTS);
    assign hit       = cache_valid_reg && ({1'b0, cursor_reg} < cache_hi_reg);
    assign found     = rd_idx_reg > cursor_reg;
    assign at_end    = ({1'b0, scan_ptr_reg} + 1'b1) == count_reg;
    assign emit_last = {1'b0, cursor_reg} >= eff_plus1;

    assign mul_sum   = {1'b0, prod_reg[PROD_W-1:DEPTH_W]}
                     + (prod_reg[0] ? {1'b0, inv_reg} : '0);
    assign rnd       = {1'b0, prod_reg[PROD_W-1:RND_SHIFT]}
                     + (PROD_W - RND_SHIFT + 1)'(prod_reg[RND_SHIFT-1]);
    assign idx_clamp = (rnd > (PROD_W - RND_SHIFT + 1)'(eff)) ? eff : rnd[GRID_W-1:0];
    assign idx_final = (idx_clamp < last_idx_reg) ? last_idx_reg : idx_clamp;

    assign diff      = {rd_val_reg[VAL_W-1], rd_val_reg} - {prev_val_reg[VAL_W-1], prev_val_reg};
    assign diff_mag  = diff[DIV_W-1] ? DIV_W'(-diff) : diff;
    assign step_val  = neg_reg ? VAL_W'(-quotient[VAL_W-1:0]) : quotient[VAL_W-1:0];

    pgi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (GRID_W'(rd_idx_reg - prev_idx_reg)),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (func)
                        state_next = ST_EM_CHK;
                    else if (!load_drop)
                        state_next = ST_LD_MUL;
                end
            ST_LD_MUL:
                if (ld_cnt_reg == LD_CNT_W'(DEPTH_W - 1))
                    state_next = ST_LD_WR;
            ST_LD_WR:
                state_next = ST_IDLE;
            ST_EM_CHK:
                state_next = (count_reg == '0 || hit) ? ST_EM_OUT : ST_SC_RD;
            ST_SC_RD:
                state_next = ST_SC_CMP;
            ST_SC_CMP:
                if (found)
                    state_next = (scan_ptr_reg == '0) ? ST_EM_OUT : ST_DIV;
                else
                    state_next = at_end ? ST_EM_OUT : ST_SC_RD;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_MUL;
            ST_MUL:
                if (mul_k_reg == '0)
                    state_next = ST_EM_OUT;
            ST_EM_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        in_accept = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                in_accept = in_valid;
            end
            ST_SC_CMP:
                div_start = found && (scan_ptr_reg != '0);
            ST_EM_OUT:
                out_load  = !out_valid_reg || !out_stall;
            default:
            begin
                in_stall  = 1'b1;
                in_accept = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gs_reg          <= GRID_STEPS_RST;
            inv_reg         <= INV_SPACING_RST;
            count_reg       <= '0;
            cursor_reg      <= '0;
            last_idx_reg    <= '0;
            cache_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRID_STEPS:  gs_reg  <= cfg_data[GRID_W-1:0];
                    CFG_INV_SPACING: inv_reg <= cfg_data[INV_W-1:0];
                    default:         gs_reg  <= gs_reg;
                endcase
            end
            if (in_accept && !func)
            begin
                cache_valid_reg <= 1'b0;
                if (first_point)
                begin
                    count_reg    <= '0;
                    cursor_reg   <= '0;
                    last_idx_reg <= '0;
                end
            end
            if (state_reg == ST_LD_WR)
            begin
                count_reg    <= count_reg + 1'b1;
                last_idx_reg <= idx_final;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (!res_empty_reg)
                begin
                    // advance the cursor; drop the cached segment on wrap
                    cursor_reg      <= emit_last ? '0 : cursor_reg + 1'b1;
                    cache_valid_reg <= !emit_last;
                end
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prod_reg   <= {{INV_W{1'b0}}, depth};
            ld_val_reg <= point_value;
            ld_cnt_reg <= '0;
        end
        if (state_reg == ST_LD_MUL)
        begin
            prod_reg   <= {mul_sum, prod_reg[DEPTH_W-1:1]};
            ld_cnt_reg <= ld_cnt_reg + 1'b1;
        end
        if (state_reg == ST_EM_CHK)
        begin
            res_empty_reg <= count_reg == '0;
            res_val_reg   <= (count_reg == '0) ? '0 : cache_acc_reg;
            scan_ptr_reg  <= '0;
        end
        if (state_reg == ST_SC_CMP)
        begin
            if (found && scan_ptr_reg == '0)
            begin
                // before the first breakpoint: hold its value
                cache_hi_reg   <= {1'b0, rd_idx_reg};
                cache_step_reg <= '0;
                res_val_reg    <= rd_val_reg;
            end
            else if (found)
            begin
                cache_hi_reg <= {1'b0, rd_idx_reg};
                neg_reg      <= diff[DIV_W-1];
            end
            else
            begin
                prev_idx_reg <= rd_idx_reg;
                prev_val_reg <= rd_val_reg;
                scan_ptr_reg <= scan_ptr_reg + 1'b1;
                if (at_end)
                begin
                    // past the last breakpoint: hold the last value
                    cache_hi_reg   <= (GRID_W + 1)'(1) << GRID_W;
                    cache_step_reg <= '0;
                    res_val_reg    <= rd_val_reg;
                end
            end
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            cache_step_reg <= step_val;
            mul_m_reg      <= step_val;
            mul_k_reg      <= cursor_reg - prev_idx_reg;
            res_val_reg    <= prev_val_reg;
        end
        if (state_reg == ST_MUL && mul_k_reg != '0)
        begin
            if (mul_k_reg[0])
                res_val_reg <= res_val_reg + mul_m_reg;
            mul_m_reg <= {mul_m_reg[VAL_W-2:0], 1'b0};
            mul_k_reg <= {1'b0, mul_k_reg[GRID_W-1:1]};
        end
        if (out_load)
        begin
            out_idx_reg   <= res_empty_reg ? '0 : cursor_reg;
            out_val_reg   <= res_val_reg;
            out_last_reg  <= !res_empty_reg && emit_last;
            out_empty_reg <= res_empty_reg;
            if (!res_empty_reg)
                cache_acc_reg <= res_val_reg + cache_step_reg;
        end
    end

    // breakpoint table
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LD_WR)
        begin
            mem_idx[count_reg[PTR_W-1:0]] <= idx_final;
            mem_val[count_reg[PTR_W-1:0]] <= ld_val_reg;
        end
        rd_idx_reg <= mem_idx[scan_ptr_reg];
        rd_val_reg <= mem_val[scan_ptr_reg];
    end

    assign out_valid    = out_valid_reg;
    assign grid_index   = out_idx_reg;
    assign sample_value = out_val_reg;
    assign last_sample  = out_last_reg;
    assign table_empty  = out_empty_reg;

    `PGI_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_POINTS), "breakpoint count overflow")
    `PGI_ASSERT_NOW(a_div_done_state, div_stat.done, state_reg == ST_DIV, "divider finished outside DIV")
    `PGI_ASSERT_NEXT(a_emit_dispatch, state_reg == ST_IDLE && in_valid && func, state_reg == ST_EM_CHK, "emit beat not dispatched")
    `PGI_ASSERT_NOW(a_empty_result, out_valid && table_empty, sample_value == '0 && !last_sample && grid_index == '0, "empty result carries data")

endmodule
